// ----- rtl/sorted_priority_queue_macros.svh -----
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// clocked assertion, off while reset is high
`define SRTPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define SRTPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/srtpq_pkg.sv -----
`default_nettype none

package srtpq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TAG_BITS_DEF  = 16;
  localparam int PRIO_BITS_DEF = 16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/srtpq_ctrl.sv -----
`default_nettype none

module srtpq_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output srtpq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (cmd.exec) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      // load a fresh result, or drop the one just taken
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/srtpq_datapath.sv -----
`default_nettype none

module srtpq_datapath #(
  parameter int DEPTH     = srtpq_pkg::DEPTH_DEF,
  parameter int TAG_BITS  = srtpq_pkg::TAG_BITS_DEF,
  parameter int PRIO_BITS = srtpq_pkg::PRIO_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  srtpq_pkg::ctrl_cmd_t cmd,
  input  wire [1:0]            mode,
  input  wire [PRIO_BITS-1:0]  priority_req,
  input  wire [TAG_BITS-1:0]   tag,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic                 head_valid,
  output logic [1:0]           status,
  output logic [CNT_W-1:0]     occupancy
);

  logic [1:0]           req_mode;
  logic [PRIO_BITS-1:0] req_prio;
  logic [TAG_BITS-1:0]  req_tag;

  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag  [DEPTH];
  logic [CNT_W-1:0]     count;
  logic [DEPTH-1:0]     ge;
  logic                 full;
  logic                 empty;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // hold the request until the cell update runs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_prio <= priority_req;
      req_tag  <= tag;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < count) && (cell_prio[i] >= req_prio);

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        case (req_mode)
          srtpq_pkg::MODE_INSERT: begin
            if (!full && !ge[i]) begin
              if (i == 0) begin
                cell_prio[i] <= req_prio;
                cell_tag[i]  <= req_tag;
              end else if (ge[(i == 0) ? 0 : i - 1]) begin
                cell_prio[i] <= req_prio;
                cell_tag[i]  <= req_tag;
              end else begin
                cell_prio[i] <= cell_prio[(i == 0) ? 0 : i - 1];
                cell_tag[i]  <= cell_tag[(i == 0) ? 0 : i - 1];
              end
            end
          end
          srtpq_pkg::MODE_REMOVE: begin
            if (!empty && (i < DEPTH - 1)) begin
              cell_prio[i] <= cell_prio[(i < DEPTH - 1) ? i + 1 : i];
              cell_tag[i]  <= cell_tag[(i < DEPTH - 1) ? i + 1 : i];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      case (req_mode)
        srtpq_pkg::MODE_INSERT: begin
          if (!full) begin
            count <= count + CNT_W'(1);
          end
        end
        srtpq_pkg::MODE_REMOVE: begin
          if (!empty) begin
            count <= count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      head_tag   <= '0;
      head_valid <= 1'b0;
      status     <= srtpq_pkg::ST_OK;
      occupancy  <= count;
      case (req_mode)
        srtpq_pkg::MODE_INSERT: begin
          if (full) begin
            status <= srtpq_pkg::ST_FULL;
          end else begin
            occupancy <= count + CNT_W'(1);
          end
        end
        srtpq_pkg::MODE_REMOVE: begin
          if (empty) begin
            status <= srtpq_pkg::ST_EMPTY;
          end else begin
            head_tag   <= cell_tag[0];
            head_valid <= 1'b1;
            occupancy  <= count - CNT_W'(1);
          end
        end
        srtpq_pkg::MODE_PEEK: begin
          if (empty) begin
            status <= srtpq_pkg::ST_EMPTY;
          end else begin
            head_tag   <= cell_tag[0];
            head_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue of DEPTH entries held in a chain of register cells in
// descending priority order; equal priorities leave in arrival order. Each
// request is captured in the request register; in the update step, every cell
// compares its priority with the new one in parallel and shifts, inserts or
// holds, loading the result into the output register. A new request is taken
// while that result waits; the update step stalls only while an untaken result
// still holds the output register. Reset clears the entry count, state and out_valid.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH     = srtpq_pkg::DEPTH_DEF,
  parameter int TAG_BITS  = srtpq_pkg::TAG_BITS_DEF,
  parameter int PRIO_BITS = srtpq_pkg::PRIO_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [1:0]            mode,
  input  wire [PRIO_BITS-1:0]  priority_req,
  input  wire [TAG_BITS-1:0]   tag,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic                 head_valid,
  output logic [1:0]           status,
  output logic [CNT_W-1:0]     occupancy
);

  srtpq_pkg::ctrl_cmd_t cmd;

  srtpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  srtpq_datapath #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .priority_req (priority_req),
    .tag          (tag),
    .head_tag     (head_tag),
    .head_valid   (head_valid),
    .status       (status),
    .occupancy    (occupancy)
  );

endmodule

`default_nettype wire

// ----- rtl/srtpq_checker.sv -----
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module srtpq_checker #(
  parameter int DEPTH     = srtpq_pkg::DEPTH_DEF,
  parameter int TAG_BITS  = srtpq_pkg::TAG_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [TAG_BITS-1:0]  head_tag,
  input wire                 head_valid,
  input wire [1:0]           status,
  input wire [CNT_W-1:0]     occupancy
);

  `SRTPQ_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(head_tag) && $stable(status)
      && $stable(occupancy),
    "stalled result changed")
  `SRTPQ_ASSERT(a_fail_no_head,
    out_valid && (status != srtpq_pkg::ST_OK) |-> !head_valid && (head_tag == '0),
    "failed request carries a head")
  `SRTPQ_ASSERT(a_full_count,
    out_valid && (status == srtpq_pkg::ST_FULL) |-> occupancy == CNT_W'(DEPTH),
    "full status below capacity")
  `SRTPQ_ASSERT(a_empty_count,
    out_valid && (status == srtpq_pkg::ST_EMPTY) |-> occupancy == '0,
    "empty status with entries held")
  `SRTPQ_ASSERT_ALWAYS(a_count_range,
    out_valid |-> occupancy <= CNT_W'(DEPTH),
    "occupancy above capacity")

endmodule

bind sorted_priority_queue srtpq_checker #(
  .DEPTH     (DEPTH),
  .TAG_BITS  (TAG_BITS)
) u_srtpq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .head_tag     (head_tag),
  .head_valid   (head_valid),
  .status       (status),
  .occupancy    (occupancy)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int QDEPTH = srtpq_pkg::DEPTH_DEF;
  localparam int TW     = srtpq_pkg::TAG_BITS_DEF;
  localparam int PW     = srtpq_pkg::PRIO_BITS_DEF;
  localparam int CW     = $clog2(srtpq_pkg::DEPTH_DEF + 1);
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int RANDOM_REQUESTS = 1850;

  typedef struct {
    logic [TW-1:0] head_tag;
    logic          head_valid;
    logic [1:0]    status;
    logic [CW-1:0] occupancy;
  } queue_result_t;

  class prio_queue_scoreboard;
    logic [PW-1:0] held_prio[QDEPTH];
    logic [TW-1:0] held_tag[QDEPTH];
    int            held_count;
    queue_result_t awaited[$];
    int            errors;

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int fill();
      return held_count;
    endfunction

    function void note_request(logic [1:0] m, logic [PW-1:0] p, logic [TW-1:0] t);
      queue_result_t r;
      int pos;
      r.head_tag = '0;
      r.head_valid = 1'b0;
      r.status = srtpq_pkg::ST_OK;
      if (m == srtpq_pkg::MODE_INSERT) begin
        if (held_count >= QDEPTH) begin
          r.status = srtpq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] >= p) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i-1];
            held_tag[i] = held_tag[i-1];
          end
          held_prio[pos] = p;
          held_tag[pos] = t;
          held_count++;
        end
      end else if (m == srtpq_pkg::MODE_REMOVE || m == srtpq_pkg::MODE_PEEK) begin
        if (held_count == 0) begin
          r.status = srtpq_pkg::ST_EMPTY;
        end else begin
          r.head_tag = held_tag[0];
          r.head_valid = 1'b1;
          if (m == srtpq_pkg::MODE_REMOVE) begin
            for (int i = 1; i < held_count; i++) begin
              held_prio[i-1] = held_prio[i];
              held_tag[i-1] = held_tag[i];
            end
            held_count--;
          end
        end
      end
      r.occupancy = held_count[CW-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic [TW-1:0] ht, logic hv, logic [1:0] st,
                               logic [CW-1:0] occ);
      queue_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result head_tag=%h head_valid=%b status=%0d occupancy=%0d",
                 $time, ht, hv, st, occ);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (ht !== e.head_tag) begin
        $display("%0t: head_tag expected %h actual %h", $time, e.head_tag, ht);
        errors++;
      end
      if (hv !== e.head_valid) begin
        $display("%0t: head_valid expected %b actual %b", $time, e.head_valid, hv);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (occ !== e.occupancy) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, occ);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    mode = srtpq_pkg::MODE_INSERT;
  logic [PW-1:0] priority_req = '0;
  logic [TW-1:0] tag = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [TW-1:0] head_tag;
  logic          head_valid;
  logic [1:0]    status;
  logic [CW-1:0] occupancy;

  prio_queue_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;

  sorted_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .priority_req(priority_req),
    .tag(tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head_tag(head_tag),
    .head_valid(head_valid),
    .status(status),
    .occupancy(occupancy)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [1:0] m, input logic [PW-1:0] p,
                              input logic [TW-1:0] t);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    priority_req <= p;
    tag <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, p, t);
  endtask

  function automatic logic [PW-1:0] pick_priority(int style);
    logic [PW-1:0] few[4];
    few[0] = '0;
    few[1] = 16'h0100;
    few[2] = 16'h8000;
    few[3] = '1;
    case (style)
      0: return PW'($urandom());
      1: return few[$urandom_range(0, 3)];
      default: return PW'($urandom_range(0, 7) << 4);
    endcase
  endfunction

  task automatic run_random();
    int sent;
    int phase;
    int kind;
    int style;
    int len;
    int r;
    logic [1:0] m;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 2);
      style = $urandom_range(0, 2);
      len = $urandom_range(20, 80);
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 2 || $urandom_range(0, 19) == 0) begin
        kind = 0;
        long_hold_req = 1'b1;
      end
      for (int k = 0; k < len && sent < RANDOM_REQUESTS; k++) begin
        r = $urandom_range(0, 99);
        case (kind)
          0: m = (r < 80) ? srtpq_pkg::MODE_INSERT :
                 (r < 92) ? srtpq_pkg::MODE_REMOVE : srtpq_pkg::MODE_PEEK;
          1: m = (r < 70) ? srtpq_pkg::MODE_REMOVE :
                 (r < 85) ? srtpq_pkg::MODE_PEEK : srtpq_pkg::MODE_INSERT;
          default: m = (r < 45) ? srtpq_pkg::MODE_INSERT :
                       (r < 80) ? srtpq_pkg::MODE_REMOVE : srtpq_pkg::MODE_PEEK;
        endcase
        if ($urandom_range(0, 99) == 0) begin
          m = MODE_NOP;
        end else begin
          sent++;
        end
        send_request(m, pick_priority(style), TW'($urandom()));
      end
      phase++;
    end
  endtask

  // receive side: random back-pressure plus the long hold on request
  initial begin
    int hold;
    int gap;
    hold = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(head_tag, head_valid, status, occupancy);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 200;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
        hold = (gap > 0) ? gap - 1 : 0;
        out_ready <= (gap == 0);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(srtpq_pkg::MODE_REMOVE, '0, '0);
    send_request(srtpq_pkg::MODE_PEEK, '0, '0);
    send_request(MODE_NOP, '1, '1);
    send_request(srtpq_pkg::MODE_INSERT, '0, '0);
    send_request(srtpq_pkg::MODE_INSERT, '1, '1);
    send_request(srtpq_pkg::MODE_INSERT, 16'h0100, 16'h0001);
    send_request(srtpq_pkg::MODE_INSERT, 16'h0100, 16'h0002);
    send_request(srtpq_pkg::MODE_INSERT, '0, 16'h0003);
    send_request(srtpq_pkg::MODE_PEEK, '0, '0);
    send_request(srtpq_pkg::MODE_REMOVE, '0, '0);
    send_request(srtpq_pkg::MODE_REMOVE, '0, '0);
    while (sb.fill() < QDEPTH) begin
      send_request(srtpq_pkg::MODE_INSERT, PW'($urandom()), TW'($urandom()));
    end
    send_request(srtpq_pkg::MODE_INSERT, 16'h4000, 16'hBEEF);
    send_request(MODE_NOP, '0, '0);

    run_random();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
    $display("** sorted_priority_queue: FAILED **");
    $finish;
  end

endmodule
